FILE: rtl/grey_sobel_edge_stream_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the grey Sobel edge stream unit
// Each macro expects a clk and an active-high rst in the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef GREY_SOBEL_EDGE_STREAM_UNIT_ASSERT_SVH
`define GREY_SOBEL_EDGE_STREAM_UNIT_ASSERT_SVH

// Same-cycle implication
`define GSES_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gses assertion failed");

// Next-cycle implication
`define GSES_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gses assertion failed");

`endif

FILE: rtl/gses_pkg.sv
// ---------------------------------------------------------------------------
// gses_pkg
// Shared types and constants of the grey Sobel edge stream unit.
// ---------------------------------------------------------------------------
package gses_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int PIX_W  = 8;
  localparam int POS_W  = 11;
  localparam int SIZE_W = 12;
  localparam int WGT_W  = 8;
  localparam int IDX_W  = 3;

  localparam logic [SIZE_W-1:0] MIN_SIZE       = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] MAX_WIDTH_SZ   = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_HEIGHT_SZ  = SIZE_W'(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] WIDTH_RESET    = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET   = SIZE_W'(480);
  localparam logic [WGT_W-1:0]  RED_RESET      = WGT_W'(77);
  localparam logic [WGT_W-1:0]  GREEN_RESET    = WGT_W'(150);
  localparam logic [WGT_W-1:0]  BLUE_RESET     = WGT_W'(29);

  typedef enum logic [IDX_W-1:0] {
    REG_LINE_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_RED_COEF     = 3'd2,
    REG_GREEN_COEF   = 3'd3,
    REG_BLUE_COEF    = 3'd4
  } cfg_reg_e;

  // per-stage control shared by the datapath modules
  typedef struct packed {
    logic advance;   // whole pipeline moves one stage
    logic load;      // the stage feeding this unit holds a pixel
  } pipe_ctl_t;

  // tag carried alongside a pixel through the pipeline
  typedef struct packed {
    logic             valid;
    logic             emit;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pix_tag_t;

endpackage

FILE: rtl/gses_ram.sv
// ---------------------------------------------------------------------------
// gses_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module gses_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/gses_grey.sv
// ---------------------------------------------------------------------------
// gses_grey
// Weighted BGR to grey conversion, products then sum, two register stages.
// ---------------------------------------------------------------------------
module gses_grey (
  input  logic                         clk,
  input  gses_pkg::pipe_ctl_t          ctl,
  input  logic [gses_pkg::PIX_W-1:0]   blue,
  input  logic [gses_pkg::PIX_W-1:0]   green,
  input  logic [gses_pkg::PIX_W-1:0]   red,
  input  logic [gses_pkg::WGT_W-1:0]   red_coef,
  input  logic [gses_pkg::WGT_W-1:0]   green_coef,
  input  logic [gses_pkg::WGT_W-1:0]   blue_coef,
  output logic [gses_pkg::PIX_W-1:0]   grey
);

  localparam int PROD_W = gses_pkg::PIX_W + gses_pkg::WGT_W;
  localparam int SUM_W  = PROD_W + 2;

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_g;
  logic [PROD_W-1:0] prod_b;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-9:0]  scaled;
  logic [gses_pkg::PIX_W-1:0] grey_next;

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      prod_r <= PROD_W'(red)   * PROD_W'(red_coef);
      prod_g <= PROD_W'(green) * PROD_W'(green_coef);
      prod_b <= PROD_W'(blue)  * PROD_W'(blue_coef);
    end
  end

  always_comb begin
    sum       = SUM_W'(prod_r) + SUM_W'(prod_g) + SUM_W'(prod_b);
    scaled    = sum[SUM_W-1:8];
    // saturate to the pixel range
    grey_next = (|scaled[SUM_W-9:gses_pkg::PIX_W]) ? '1 : scaled[gses_pkg::PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.advance && ctl.load) begin
      grey <= grey_next;
    end
  end

endmodule

FILE: rtl/gses_sobel.sv
// ---------------------------------------------------------------------------
// gses_sobel
// 3x3 window shift register and saturated |Gx|+|Gy| magnitude.
// ---------------------------------------------------------------------------
module gses_sobel (
  input  logic                         clk,
  input  logic                         rst,
  input  gses_pkg::pipe_ctl_t          ctl,
  input  logic [gses_pkg::PIX_W-1:0]   top,
  input  logic [gses_pkg::PIX_W-1:0]   mid,
  input  logic [gses_pkg::PIX_W-1:0]   bot,
  output logic [gses_pkg::PIX_W-1:0]   edge_value
);

  localparam int W  = gses_pkg::PIX_W;
  localparam int S3 = W + 2;

  // index 0 is the left column, 2 the newest
  logic [W-1:0] win_t [3];
  logic [W-1:0] win_m [3];
  logic [W-1:0] win_b [3];

  logic [S3-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
  logic [S3-1:0] gx_abs, gy_abs;
  logic [S3:0]   mag;
  logic [W-1:0]  edge_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win_t[i] <= '0;
        win_m[i] <= '0;
        win_b[i] <= '0;
      end
    end else if (ctl.advance && ctl.load) begin
      for (int i = 0; i < 2; i++) begin
        win_t[i] <= win_t[i+1];
        win_m[i] <= win_m[i+1];
        win_b[i] <= win_b[i+1];
      end
      win_t[2] <= top;
      win_m[2] <= mid;
      win_b[2] <= bot;
    end
  end

  always_comb begin
    gx_pos = S3'(win_t[2]) + {1'b0, win_m[2], 1'b0} + S3'(win_b[2]);
    gx_neg = S3'(win_t[0]) + {1'b0, win_m[0], 1'b0} + S3'(win_b[0]);
    gy_pos = S3'(win_t[0]) + {1'b0, win_t[1], 1'b0} + S3'(win_t[2]);
    gy_neg = S3'(win_b[0]) + {1'b0, win_b[1], 1'b0} + S3'(win_b[2]);
    gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
    gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
    mag    = (S3+1)'(gx_abs) + (S3+1)'(gy_abs);
    edge_next = (|mag[S3:W]) ? '1 : mag[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      edge_value <= edge_next;
    end
  end

endmodule

FILE: rtl/grey_sobel_edge_stream_unit.sv
// ---------------------------------------------------------------------------
// grey_sobel_edge_stream_unit
// Grey conversion and 3x3 Sobel edge magnitude on a raster pixel stream.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one BGR pixel per transfer in raster order. m_axis carries
//   one result per interior pixel: the saturated |Gx|+|Gy|, the pixel's row
//   and column, and tlast on the last interior pixel of the frame. Border
//   pixels produce no transfer.
//   cfg writes the size and weight registers; write only while idle.
// Throughput: one pixel per cycle while m_axis does not stall. The pixel
//   that completes a window passes stages A, B, C and the output register.
//   Two line memories (2048 x 8, one read and one write port each) are read
//   at the pixel's column when it is taken and written back from stage B;
//   the line width of at least three keeps the read and the write apart.
// Reset: registers return to 640 x 480 and weights 77/150/29, the position
//   counters and the window clear; line memories are not cleared.
// Stall: with m_axis_tready low and a result held, the whole pipeline holds
//   and s_axis_tready drops in the same cycle.
// ---------------------------------------------------------------------------
`include "grey_sobel_edge_stream_unit_assert.svh"

module grey_sobel_edge_stream_unit (
  input  logic                         clk,
  input  logic                         rst,
  // slave stream: [7:0] blue, [15:8] green, [23:16] red
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [23:0]                  s_axis_tdata,
  // master stream: [7:0] edge_value, [18:8] out_row, [29:19] out_col, zero fill
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [31:0]                  m_axis_tdata,
  output logic                         m_axis_tlast,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gses_pkg::IDX_W-1:0]   cfg_index,
  input  logic [gses_pkg::SIZE_W-1:0]  cfg_data
);

  localparam int PW = gses_pkg::POS_W;
  localparam int SW = gses_pkg::SIZE_W;

  logic [SW-1:0]               line_width;
  logic [SW-1:0]               frame_height;
  logic [gses_pkg::WGT_W-1:0]  red_coef;
  logic [gses_pkg::WGT_W-1:0]  green_coef;
  logic [gses_pkg::WGT_W-1:0]  blue_coef;

  logic [SW-1:0] width_eff;
  logic [SW-1:0] height_eff;

  logic [PW-1:0] column_count;
  logic [PW-1:0] row_count;
  logic [PW-1:0] column_count_next;
  logic [PW-1:0] row_count_next;
  logic [SW-1:0] col_inc;
  logic [SW-1:0] row_inc;

  logic advance;
  logic in_accept;
  logic wr_en;

  gses_pkg::pix_tag_t tag_in;
  gses_pkg::pix_tag_t tag_a;
  gses_pkg::pix_tag_t tag_b;
  gses_pkg::pix_tag_t tag_c;
  gses_pkg::pipe_ctl_t grey_ctl;
  gses_pkg::pipe_ctl_t sobel_ctl;

  logic [gses_pkg::PIX_W-1:0] upper_rd;
  logic [gses_pkg::PIX_W-1:0] middle_rd;
  logic [gses_pkg::PIX_W-1:0] top_b;
  logic [gses_pkg::PIX_W-1:0] mid_b;
  logic [gses_pkg::PIX_W-1:0] grey_b;
  logic [gses_pkg::PIX_W-1:0] edge_value;

  logic          out_valid;
  logic          out_last;
  logic [PW-1:0] out_row;
  logic [PW-1:0] out_col;

  // -------------------------------------------------------------------------
  // configuration
  // -------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= gses_pkg::WIDTH_RESET;
      frame_height <= gses_pkg::HEIGHT_RESET;
      red_coef     <= gses_pkg::RED_RESET;
      green_coef   <= gses_pkg::GREEN_RESET;
      blue_coef    <= gses_pkg::BLUE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gses_pkg::REG_LINE_WIDTH:   line_width   <= cfg_data;
        gses_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        gses_pkg::REG_RED_COEF:     red_coef     <= cfg_data[gses_pkg::WGT_W-1:0];
        gses_pkg::REG_GREEN_COEF:   green_coef   <= cfg_data[gses_pkg::WGT_W-1:0];
        gses_pkg::REG_BLUE_COEF:    blue_coef    <= cfg_data[gses_pkg::WGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (line_width < gses_pkg::MIN_SIZE) begin
      width_eff = gses_pkg::MIN_SIZE;
    end else if (line_width > gses_pkg::MAX_WIDTH_SZ) begin
      width_eff = gses_pkg::MAX_WIDTH_SZ;
    end else begin
      width_eff = line_width;
    end
    if (frame_height < gses_pkg::MIN_SIZE) begin
      height_eff = gses_pkg::MIN_SIZE;
    end else if (frame_height > gses_pkg::MAX_HEIGHT_SZ) begin
      height_eff = gses_pkg::MAX_HEIGHT_SZ;
    end else begin
      height_eff = frame_height;
    end
  end

  // -------------------------------------------------------------------------
  // handshake and raster position
  // -------------------------------------------------------------------------
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = advance;
  assign in_accept     = s_axis_tvalid && advance;

  always_comb begin
    col_inc           = SW'(column_count) + SW'(1);
    row_inc           = SW'(row_count) + SW'(1);
    column_count_next = col_inc[PW-1:0];
    row_count_next    = row_count;
    // wrap at the end of a row, and at the end of the frame
    if (col_inc >= width_eff) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= height_eff) ? '0 : row_inc[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  always_comb begin
    tag_in.valid = in_accept;
    tag_in.emit  = (row_count >= PW'(2)) && (column_count >= PW'(2));
    tag_in.last  = (SW'(row_count) == height_eff - SW'(1)) &&
                   (SW'(column_count) == width_eff - SW'(1));
    tag_in.row   = row_count;
    tag_in.col   = column_count;
  end

  // -------------------------------------------------------------------------
  // pipeline: A products + line read, B grey + write back, C window, output
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a     <= '0;
      tag_b     <= '0;
      tag_c     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      tag_a     <= tag_in;
      tag_b     <= tag_a;
      tag_c     <= tag_b;
      out_valid <= tag_c.valid && tag_c.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_last <= tag_c.last;
      out_row  <= tag_c.row - PW'(1);
      out_col  <= tag_c.col - PW'(1);
    end
    if (advance && tag_a.valid) begin
      top_b <= upper_rd;
      mid_b <= middle_rd;
    end
  end

  assign grey_ctl.advance  = advance;
  assign grey_ctl.load     = tag_a.valid;
  assign sobel_ctl.advance = advance;
  assign sobel_ctl.load    = tag_b.valid;

  assign wr_en = advance && tag_b.valid;

  gses_grey u_grey (
    .clk        (clk),
    .ctl        (grey_ctl),
    .blue       (s_axis_tdata[7:0]),
    .green      (s_axis_tdata[15:8]),
    .red        (s_axis_tdata[23:16]),
    .red_coef   (red_coef),
    .green_coef (green_coef),
    .blue_coef  (blue_coef),
    .grey       (grey_b)
  );

  // upper line takes the old middle value, middle line takes the new grey
  gses_ram #(
    .WIDTH (gses_pkg::PIX_W),
    .DEPTH (gses_pkg::MAX_WIDTH)
  ) u_line_upper (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tag_b.col),
    .wr_data (mid_b),
    .rd_en   (in_accept),
    .rd_addr (column_count),
    .rd_data (upper_rd)
  );

  gses_ram #(
    .WIDTH (gses_pkg::PIX_W),
    .DEPTH (gses_pkg::MAX_WIDTH)
  ) u_line_middle (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tag_b.col),
    .wr_data (grey_b),
    .rd_en   (in_accept),
    .rd_addr (column_count),
    .rd_data (middle_rd)
  );

  gses_sobel u_sobel (
    .clk        (clk),
    .rst        (rst),
    .ctl        (sobel_ctl),
    .top        (top_b),
    .mid        (mid_b),
    .bot        (grey_b),
    .edge_value (edge_value)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {2'b00, out_col, out_row, edge_value};

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  // a line read never hits the entry being written back in the same cycle
  `GSES_ASSERT_IMP(a_no_rw_overlap, in_accept && wr_en, column_count != tag_b.col)
  // a taken pixel enters stage A
  `GSES_ASSERT_NXT(a_accept_loads, in_accept, tag_a.valid && tag_a.col == $past(column_count))
  // a held stall freezes the write-back stage
  `GSES_ASSERT_NXT(a_stall_holds, !advance, $stable(tag_b) && $stable(tag_c))
  // the frame end mark sits on the row next to the bottom border
  `GSES_ASSERT_IMP(a_last_row, out_valid && out_last,
                   SW'(out_row) + SW'(2) == height_eff)

endmodule
